// ===== sv/pcbp_pkg.sv =====
// Shared types, constants and register codes of the prefix-coded bit packer.
`default_nettype none

package pcbp_pkg;

    localparam int DATA_W      = 64;
    localparam int VAL_W       = 40;
    localparam int WID_W       = 6;
    localparam int BYTE_W      = 8;
    localparam int POS_W       = 3;
    localparam int IDX_W       = 16;
    localparam int ID_W        = 16;
    localparam int BITS_W      = 5;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OPCODE_W    = 3;
    localparam int S_TDATA_W   = 72;
    localparam int S_TUSER_W   = 5;
    localparam int M_TDATA_W   = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [DATA_W-1:0] TIME_LIMIT_SHORT  = 64'd16383;
    localparam logic [DATA_W-1:0] TIME_LIMIT_MEDIUM = 64'd262143;
    localparam logic [DATA_W-1:0] TIME_LIMIT_LONG   = 64'd67108863;
    localparam int TIME_SHIFT  = 5;
    localparam int RAW_MAX     = 32;
    localparam int ID_BITS_MAX = 16;

    localparam logic [CFG_DATA_W-1:0] RESET_LOW_ID_BITS    = 16'd8;
    localparam logic [CFG_DATA_W-1:0] RESET_MEDIUM_ID_BITS = 16'd12;
    localparam logic [CFG_DATA_W-1:0] RESET_HIGH_ID_BITS   = 16'd16;
    localparam logic [CFG_DATA_W-1:0] RESET_BUFFER_BYTES   = 16'd1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_START  = 3'd0,
        OP_RAW    = 3'd1,
        OP_TIME   = 3'd2,
        OP_NET_ID = 3'd3,
        OP_FLUSH  = 3'd4
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MULTIPLAYER     = 3'd0,
        REG_LOW_ID_COUNT    = 3'd1,
        REG_LOW_ID_BITS     = 3'd2,
        REG_MEDIUM_ID_BITS  = 3'd3,
        REG_HIGH_ID_START   = 3'd4,
        REG_HIGH_ID_BITS    = 3'd5,
        REG_INVALID_ID_CODE = 3'd6,
        REG_BUFFER_BYTES    = 3'd7
    } cfg_index_t;

    typedef enum logic [1:0] {
        JOB_START  = 2'd0,
        JOB_APPEND = 2'd1,
        JOB_FLUSH  = 2'd2
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [VAL_W-1:0]  value;
        logic [WID_W-1:0]  width;
    } job_t;

    typedef struct packed {
        logic              multiplayer;
        logic [ID_W-1:0]   low_id_count;
        logic [BITS_W-1:0] low_id_bits;
        logic [BITS_W-1:0] medium_id_bits;
        logic [ID_W-1:0]   high_id_start;
        logic [BITS_W-1:0] high_id_bits;
        logic [ID_W-1:0]   invalid_id_code;
        logic [IDX_W-1:0]  buffer_bytes;
    } cfg_t;

endpackage

`default_nettype wire

// ===== sv/prefix_coded_bit_packer_top.sv =====
// Top level of the prefix-coded bit packer: config registers, front, queue, back.
//
//  channel  dir  handshake        payload
//  s_*      in   tvalid/tready    tdata: data_value[63:0], bit_count[69:64]
//                                 tuser: opcode[2:0], time_scaled[3], id_invalid[4]
//  m_*      out  tvalid/tready    tdata: out_byte[7:0], byte_index[23:8];
//                                 tlast: last; tuser: failed
//  cfg_*    in   cfg_we           cfg_index selects register, cfg_data[15:0]
//
//  The front decodes an item in the cycle it is accepted and queues at most one job.
//  The back handles one output byte that the item's bits reach per cycle
//  while the output is not stalled; a job whose bits span bytes stays active
//  until all of them are placed.
//  Completed bytes pass through an output register; a stall on m_tready
//  holds the back while the queue keeps taking items until full.
//  Reset clears the bit and byte positions, the failed flag and all valids.
`default_nettype none

module prefix_coded_bit_packer_top (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [pcbp_pkg::S_TDATA_W-1:0]    s_tdata,  // data_value, bit_count
    input  wire logic [pcbp_pkg::S_TUSER_W-1:0]    s_tuser,  // opcode, time_scaled, id_invalid
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [pcbp_pkg::M_TDATA_W-1:0]         m_tdata,  // out_byte, byte_index
    output logic                                   m_tlast,
    output logic [0:0]                             m_tuser,  // failed
    input  wire logic                              cfg_we,
    input  wire logic [pcbp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pcbp_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import pcbp_pkg::*;

    cfg_t cfg_reg;
    job_t front_job;
    logic front_ok;
    logic q_ready;
    logic q_push;
    job_t q_job;
    logic q_valid;
    logic q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.multiplayer     <= 1'b0;
            cfg_reg.low_id_count    <= '0;
            cfg_reg.low_id_bits     <= RESET_LOW_ID_BITS[BITS_W-1:0];
            cfg_reg.medium_id_bits  <= RESET_MEDIUM_ID_BITS[BITS_W-1:0];
            cfg_reg.high_id_start   <= '0;
            cfg_reg.high_id_bits    <= RESET_HIGH_ID_BITS[BITS_W-1:0];
            cfg_reg.invalid_id_code <= '0;
            cfg_reg.buffer_bytes    <= RESET_BUFFER_BYTES;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_MULTIPLAYER:     cfg_reg.multiplayer     <= cfg_data[0];
                REG_LOW_ID_COUNT:    cfg_reg.low_id_count    <= cfg_data[ID_W-1:0];
                REG_LOW_ID_BITS:     cfg_reg.low_id_bits     <= cfg_data[BITS_W-1:0];
                REG_MEDIUM_ID_BITS:  cfg_reg.medium_id_bits  <= cfg_data[BITS_W-1:0];
                REG_HIGH_ID_START:   cfg_reg.high_id_start   <= cfg_data[ID_W-1:0];
                REG_HIGH_ID_BITS:    cfg_reg.high_id_bits    <= cfg_data[BITS_W-1:0];
                REG_INVALID_ID_CODE: cfg_reg.invalid_id_code <= cfg_data[ID_W-1:0];
                REG_BUFFER_BYTES:    cfg_reg.buffer_bytes    <= cfg_data[IDX_W-1:0];
                default:             cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    assign s_tready = q_ready;
    assign q_push   = s_tvalid && q_ready && front_ok;

    pcbp_front u_front (
        .opcode      (s_tuser[OPCODE_W-1:0]),
        .data_value  (s_tdata[DATA_W-1:0]),
        .bit_count   (s_tdata[DATA_W +: WID_W]),
        .time_scaled (s_tuser[OPCODE_W]),
        .id_invalid  (s_tuser[OPCODE_W+1]),
        .cfg         (cfg_reg),
        .job         (front_job),
        .job_ok      (front_ok)
    );

    pcbp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .in_job  (front_job),
        .ready   (q_ready),
        .out_job (q_job),
        .valid   (q_valid),
        .pop     (q_pop)
    );

    pcbp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .buffer_bytes (cfg_reg.buffer_bytes),
        .job          (q_job),
        .job_valid    (q_valid),
        .job_pop      (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser)
    );

endmodule

`default_nettype wire

// ===== sv/pcbp_front.sv =====
// Front end: decodes an input item into a left-aligned bit string job.
`default_nettype none

module pcbp_front (
    input  wire logic [pcbp_pkg::OPCODE_W-1:0] opcode,
    input  wire logic [pcbp_pkg::DATA_W-1:0]   data_value,
    input  wire logic [pcbp_pkg::WID_W-1:0]    bit_count,
    input  wire logic                          time_scaled,
    input  wire logic                          id_invalid,
    input  pcbp_pkg::cfg_t                     cfg,
    output pcbp_pkg::job_t                     job,
    output logic                               job_ok
);
    import pcbp_pkg::*;

    function automatic logic [BITS_W-1:0] clamp_id_bits(input logic [BITS_W-1:0] w);
        return (w > BITS_W'(ID_BITS_MAX)) ? BITS_W'(ID_BITS_MAX) : w;
    endfunction

    logic [DATA_W-1:0] t;
    logic [WID_W-1:0]  raw_cnt;
    logic [VAL_W-1:0]  raw_mask;
    logic [ID_W-1:0]   id;
    logic              in_low;
    logic              in_med;
    logic [BITS_W-1:0] idw;
    logic [ID_W-1:0]   diff;
    logic [ID_W:0]     id_mask;
    logic [ID_W-1:0]   payload;
    logic [VAL_W-1:0]  raw;
    logic [WID_W-1:0]  width;
    logic [WID_W-1:0]  pad;

    always_comb
    begin
        t        = time_scaled ? (data_value >> TIME_SHIFT) : data_value;
        raw_cnt  = (bit_count > WID_W'(RAW_MAX)) ? WID_W'(RAW_MAX) : bit_count;
        raw_mask = (VAL_W'(1) << raw_cnt) - VAL_W'(1);

        id     = id_invalid ? cfg.invalid_id_code : data_value[ID_W-1:0];
        in_low = id < cfg.low_id_count;
        in_med = id < cfg.high_id_start;
        if (in_low)
        begin
            idw  = clamp_id_bits(cfg.low_id_bits);
            diff = id;
        end
        else if (in_med)
        begin
            idw  = clamp_id_bits(cfg.medium_id_bits);
            diff = id - cfg.low_id_count;
        end
        else
        begin
            idw  = clamp_id_bits(cfg.high_id_bits);
            diff = id - cfg.high_id_start;
        end
        id_mask = ((ID_W+1)'(1) << idw) - (ID_W+1)'(1);
        payload = diff & id_mask[ID_W-1:0];

        raw      = '0;
        width    = '0;
        job_ok   = 1'b0;
        job.kind = JOB_APPEND;

        unique case (opcode_t'(opcode))
            OP_START:
            begin
                job.kind = JOB_START;
                raw      = VAL_W'(data_value[BYTE_W-1:0]);
                width    = WID_W'(BYTE_W);
                job_ok   = 1'b1;
            end
            OP_RAW:
            begin
                raw    = data_value[VAL_W-1:0] & raw_mask;
                width  = raw_cnt;
                job_ok = raw_cnt != '0;
            end
            OP_TIME:
            begin
                job_ok = 1'b1;
                if (t < TIME_LIMIT_SHORT)
                begin
                    raw   = VAL_W'({2'd0, t[13:0]});
                    width = WID_W'(16);
                end
                else if (t < TIME_LIMIT_MEDIUM)
                begin
                    raw   = VAL_W'({2'd1, t[17:0]});
                    width = WID_W'(20);
                end
                else if (t < TIME_LIMIT_LONG)
                begin
                    raw   = VAL_W'({2'd2, t[25:0]});
                    width = WID_W'(28);
                end
                else
                begin
                    raw   = {2'd3, t[37:0]};
                    width = WID_W'(VAL_W);
                end
            end
            OP_NET_ID:
            begin
                job_ok = 1'b1;
                if (!cfg.multiplayer)
                begin
                    raw   = VAL_W'(data_value[ID_W-1:0]);
                    width = WID_W'(ID_W);
                end
                else if (in_low)
                begin
                    raw   = VAL_W'(payload);
                    width = WID_W'(idw) + WID_W'(1);
                end
                else
                begin
                    raw   = (VAL_W'({1'b1, !in_med}) << idw) | VAL_W'(payload);
                    width = WID_W'(idw) + WID_W'(2);
                end
            end
            OP_FLUSH:
            begin
                job.kind = JOB_FLUSH;
                job_ok   = 1'b1;
            end
            default:
            begin
                job_ok = 1'b0;
            end
        endcase

        pad       = WID_W'(VAL_W) - width;
        job.value = raw << pad;
        job.width = width;
    end

endmodule

`default_nettype wire

// ===== sv/pcbp_queue.sv =====
// Short job queue between the front end and the byte packer.
`default_nettype none

module pcbp_queue (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  pcbp_pkg::job_t in_job,
    output logic           ready,
    output pcbp_pkg::job_t out_job,
    output logic           valid,
    input  wire logic      pop
);
    import pcbp_pkg::*;

    job_t                   mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    function automatic logic [QUEUE_PTR_W-1:0] advance(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_PTR_W'(1);
    endfunction

    assign ready   = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign valid   = count_reg != '0;
    assign out_job = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? advance(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? advance(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + QUEUE_CNT_W'(push) - QUEUE_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n) push |-> ready)
        else $error("queue push while full");
    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n) pop |-> valid)
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QUEUE_CNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== sv/pcbp_back.sv =====
// Back end: shifts job bits into the partial byte and emits completed bytes.
`default_nettype none

module pcbp_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [pcbp_pkg::IDX_W-1:0]     buffer_bytes,
    input  pcbp_pkg::job_t                      job,
    input  wire logic                           job_valid,
    output logic                                job_pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pcbp_pkg::M_TDATA_W-1:0]      m_tdata,   // out_byte, byte_index
    output logic                                m_tlast,
    output logic [0:0]                          m_tuser    // failed
);
    import pcbp_pkg::*;

    logic                   active_reg;
    logic                   active_next;
    logic [VAL_W-1:0]       val_reg;
    logic [VAL_W-1:0]       val_next;
    logic [WID_W-1:0]       rem_reg;
    logic [WID_W-1:0]       rem_next;
    logic [POS_W-1:0]       bitpos_reg;
    logic [POS_W-1:0]       bitpos_next;
    logic [BYTE_W-1:0]      partial_reg;
    logic [BYTE_W-1:0]      partial_next;
    logic [IDX_W-1:0]       bytepos_reg;
    logic [IDX_W-1:0]       bytepos_next;
    logic                   ovf_reg;
    logic                   ovf_next;
    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [M_TDATA_W-1:0]   m_data_reg;
    logic [M_TDATA_W-1:0]   m_data_next;
    logic                   m_last_reg;
    logic                   m_last_next;
    logic                   m_failed_reg;
    logic                   m_failed_next;

    logic                   out_ready;
    logic                   step;
    job_kind_t              kind;
    logic [VAL_W-1:0]       cur_val;
    logic [WID_W-1:0]       cur_rem;
    logic [POS_W:0]         space;
    logic [POS_W:0]         take;
    logic                   fills;
    logic [BYTE_W-1:0]      byte_new;
    logic [WID_W-1:0]       rem_after;
    logic                   close_req;
    logic [BYTE_W-1:0]      close_byte;
    logic                   close_last;
    logic                   emit;
    logic [BYTE_W-1:0]      emit_byte;
    logic [IDX_W-1:0]       emit_idx;
    logic                   emit_last;
    logic                   emit_failed;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_failed_reg;

    always_comb
    begin
        out_ready = !m_valid_reg || m_tready;
        step      = out_ready && (active_reg || job_valid);
        kind      = active_reg ? JOB_APPEND : job.kind;
        cur_val   = active_reg ? val_reg : job.value;
        cur_rem   = active_reg ? rem_reg : job.width;
        space     = (POS_W+1)'(BYTE_W) - {1'b0, bitpos_reg};
        fills     = cur_rem >= WID_W'(space);
        take      = fills ? space : cur_rem[POS_W:0];
        byte_new  = partial_reg | (cur_val[VAL_W-1 -: BYTE_W] >> bitpos_reg);
        rem_after = cur_rem - WID_W'(take);

        active_next  = active_reg;
        val_next     = val_reg;
        rem_next     = rem_reg;
        bitpos_next  = bitpos_reg;
        partial_next = partial_reg;
        bytepos_next = bytepos_reg;
        ovf_next     = ovf_reg;
        job_pop      = 1'b0;
        close_req    = 1'b0;
        close_byte   = partial_reg;
        close_last   = 1'b1;
        emit         = 1'b0;
        emit_byte    = '0;
        emit_idx     = '0;
        emit_last    = 1'b1;
        emit_failed  = ovf_reg;

        if (step)
        begin
            job_pop = !active_reg;
            unique case (kind)
                JOB_START:
                begin
                    ovf_next     = 1'b0;
                    partial_next = '0;
                    bitpos_next  = '0;
                    bytepos_next = IDX_W'(1);
                    if (buffer_bytes != '0)
                    begin
                        emit        = 1'b1;
                        emit_byte   = cur_val[VAL_W-1 -: BYTE_W];
                        emit_failed = 1'b0;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                JOB_APPEND:
                begin
                    if (fills)
                    begin
                        close_req  = 1'b1;
                        close_byte = byte_new;
                        close_last = (rem_after < WID_W'(BYTE_W)) ||
                                     (bytepos_reg + IDX_W'(1) == buffer_bytes);
                    end
                    else
                    begin
                        partial_next = byte_new;
                        bitpos_next  = bitpos_reg + take[POS_W-1:0];
                    end
                    active_next = rem_after != '0;
                    val_next    = cur_val << take;
                    rem_next    = rem_after;
                end
                JOB_FLUSH:
                begin
                    close_req = bitpos_reg != '0;
                end
                default:
                begin
                    close_req = 1'b0;
                end
            endcase

            if (close_req)
            begin
                partial_next = '0;
                bitpos_next  = '0;
                if (bytepos_reg < buffer_bytes)
                begin
                    emit         = 1'b1;
                    emit_byte    = close_byte;
                    emit_idx     = bytepos_reg;
                    emit_last    = close_last;
                    bytepos_next = bytepos_reg + IDX_W'(1);
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
        end

        m_valid_next  = out_ready ? emit : m_valid_reg;
        m_data_next   = emit ? {emit_idx, emit_byte} : m_data_reg;
        m_last_next   = emit ? emit_last : m_last_reg;
        m_failed_next = emit ? emit_failed : m_failed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            rem_reg     <= '0;
            bitpos_reg  <= '0;
            partial_reg <= '0;
            bytepos_reg <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg  <= active_next;
            rem_reg     <= rem_next;
            bitpos_reg  <= bitpos_next;
            partial_reg <= partial_next;
            bytepos_reg <= bytepos_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_failed_reg <= m_failed_next;
    end

    a_active_has_bits: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> rem_reg != '0)
        else $error("active job with no bits left");
    a_partial_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (partial_reg & (BYTE_W'(8'hff) >> bitpos_reg)) == '0)
        else $error("partial byte has bits past the fill point");
    a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_valid_reg |-> m_data_reg[M_TDATA_W-1 -: IDX_W] < buffer_bytes)
        else $error("byte emitted beyond capacity");
    a_start_position: assert property (@(posedge clk) disable iff (!rst_n)
        (step && kind == JOB_START) |=> bytepos_reg == IDX_W'(1))
        else $error("start did not restart byte position");

endmodule

`default_nettype wire

// ===== dv/prefix_coded_bit_packer_top_tb.sv =====
// Self-checking testbench for prefix_coded_bit_packer_top against a bit-level predictor.
`timescale 1ns / 1ps

module prefix_coded_bit_packer_top_tb;
    import pcbp_pkg::*;

    localparam logic [63:0] TIME_CLASS0_END = 64'd16383;
    localparam logic [63:0] TIME_CLASS1_END = 64'd262143;
    localparam logic [63:0] TIME_CLASS2_END = 64'd67108863;
    localparam int          TIME_SCALE_SHIFT = 5;
    localparam logic [1:0]  TIME_PFX_SHORT  = 2'd0;
    localparam logic [1:0]  TIME_PFX_MEDIUM = 2'd1;
    localparam logic [1:0]  TIME_PFX_LONG   = 2'd2;
    localparam logic [1:0]  TIME_PFX_WIDE   = 2'd3;
    localparam logic        ID_PFX_LOW      = 1'b0;
    localparam logic [1:0]  ID_PFX_MEDIUM   = 2'b10;
    localparam logic [1:0]  ID_PFX_HIGH     = 2'b11;
    localparam int          RAW_BITS_MAX    = 32;
    localparam int          ID_PAYLOAD_MAX  = 16;
    localparam int          PLAIN_ID_BITS   = 16;
    localparam int          RANDOM_ITEMS    = 250;
    localparam int          PHASE_ITEMS     = 50;
    localparam int          SETTLE_CYCLES   = 24;
    localparam int          OPCODE_TOP      = (1 << OPCODE_W) - 1;

    typedef struct {
        logic [7:0]  value;
        logic [15:0] index;
        logic        last;
        logic        failed;
    } out_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;   // data_value, bit_count
    logic [S_TUSER_W-1:0]  s_tuser = '0;   // opcode, time_scaled, id_invalid
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;        // out_byte, byte_index
    logic                  m_tlast;
    logic [0:0]            m_tuser;        // failed
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic        cur_multiplayer     = 1'b0;
    logic [15:0] cur_low_id_count    = '0;
    logic [4:0]  cur_low_id_bits     = 5'd8;
    logic [4:0]  cur_medium_id_bits  = 5'd12;
    logic [15:0] cur_high_id_start   = '0;
    logic [4:0]  cur_high_id_bits    = 5'd16;
    logic [15:0] cur_invalid_id_code = '0;
    logic [15:0] cur_buffer_bytes    = 16'd1024;

    logic [15:0] byte_pos = '0;
    logic [2:0]  bit_pos  = '0;
    logic [7:0]  partial  = '0;
    logic        overflow = 1'b0;

    out_byte_t   expected_bytes[$];
    out_byte_t   item_bytes[$];
    out_byte_t   head_byte;
    int unsigned errors = 0;
    int unsigned accepted_ops = 0;
    int unsigned burst_left = 0;
    int unsigned sink_tick = 0;
    int unsigned sink_mode = 0;

    prefix_coded_bit_packer_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("prefix_coded_bit_packer_top verification failed");
        $finish;
    end

    function automatic bit store_byte(input logic [7:0] value, input logic [15:0] index);
        out_byte_t rec;
        if (index < cur_buffer_bytes)
        begin
            rec.value  = value;
            rec.index  = index;
            rec.last   = 1'b0;
            rec.failed = overflow;
            item_bytes.push_back(rec);
            return 1'b1;
        end
        overflow = 1'b1;
        return 1'b0;
    endfunction

    function automatic void close_byte();
        if (store_byte(partial, byte_pos))
            byte_pos++;
        partial = '0;
        bit_pos = '0;
    endfunction

    function automatic void shift_in(input logic [63:0] value, input int width);
        for (int i = width - 1; i >= 0; i--)
        begin
            partial[3'd7 - bit_pos] = value[i];
            if (bit_pos == 3'd7)
                close_byte();
            else
                bit_pos++;
        end
    endfunction

    function automatic int id_width(input logic [4:0] w);
        return (w > ID_PAYLOAD_MAX) ? ID_PAYLOAD_MAX : int'(w);
    endfunction

    function automatic void apply_reg(input cfg_index_t idx, input logic [15:0] value);
        case (idx)
            REG_MULTIPLAYER:     cur_multiplayer     = value[0];
            REG_LOW_ID_COUNT:    cur_low_id_count    = value;
            REG_LOW_ID_BITS:     cur_low_id_bits     = value[4:0];
            REG_MEDIUM_ID_BITS:  cur_medium_id_bits  = value[4:0];
            REG_HIGH_ID_START:   cur_high_id_start   = value;
            REG_HIGH_ID_BITS:    cur_high_id_bits    = value[4:0];
            REG_INVALID_ID_CODE: cur_invalid_id_code = value;
            default:             cur_buffer_bytes    = value;
        endcase
    endfunction

    function automatic void predict_packed_bytes(input logic [OPCODE_W-1:0] op,
                                                 input logic [63:0] value,
                                                 input logic [5:0] nbits,
                                                 input logic scaled,
                                                 input logic bad_id);
        logic [63:0] t;
        logic [15:0] id;
        logic [15:0] offset;
        int          width;
        item_bytes.delete();
        t  = scaled ? (value >> TIME_SCALE_SHIFT) : value;
        id = value[15:0];
        case (op)
            OP_START:
            begin
                overflow = 1'b0;
                partial  = '0;
                bit_pos  = '0;
                void'(store_byte(value[7:0], 16'd0));
                byte_pos = 16'd1;
            end
            OP_RAW:
            begin
                width = (nbits > RAW_BITS_MAX) ? RAW_BITS_MAX : int'(nbits);
                shift_in(value, width);
            end
            OP_TIME:
            begin
                if (t < TIME_CLASS0_END)
                begin
                    shift_in(64'(TIME_PFX_SHORT), 2);
                    shift_in(t, 14);
                end
                else if (t < TIME_CLASS1_END)
                begin
                    shift_in(64'(TIME_PFX_MEDIUM), 2);
                    shift_in(t, 18);
                end
                else if (t < TIME_CLASS2_END)
                begin
                    shift_in(64'(TIME_PFX_LONG), 2);
                    shift_in(t, 26);
                end
                else
                begin
                    shift_in(64'(TIME_PFX_WIDE), 2);
                    shift_in(t >> 32, 6);
                    shift_in(t, 32);
                end
            end
            OP_NET_ID:
            begin
                if (!cur_multiplayer)
                    shift_in(64'(id), PLAIN_ID_BITS);
                else
                begin
                    if (bad_id)
                        id = cur_invalid_id_code;
                    if (id < cur_low_id_count)
                    begin
                        shift_in(64'(ID_PFX_LOW), 1);
                        shift_in(64'(id), id_width(cur_low_id_bits));
                    end
                    else if (id < cur_high_id_start)
                    begin
                        offset = id - cur_low_id_count;
                        shift_in(64'(ID_PFX_MEDIUM), 2);
                        shift_in(64'(offset), id_width(cur_medium_id_bits));
                    end
                    else
                    begin
                        offset = id - cur_high_id_start;
                        shift_in(64'(ID_PFX_HIGH), 2);
                        shift_in(64'(offset), id_width(cur_high_id_bits));
                    end
                end
            end
            OP_FLUSH:
            begin
                if (bit_pos != 3'd0)
                    close_byte();
            end
            default:
            begin
            end
        endcase
        if (item_bytes.size() != 0)
            item_bytes[item_bytes.size() - 1].last = 1'b1;
        while (item_bytes.size() != 0)
            expected_bytes.push_back(item_bytes.pop_front());
        if (op <= OP_FLUSH)
            accepted_ops++;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected item: out_byte %0h byte_index %0d",
                       m_tdata[7:0], m_tdata[23:8]);
                errors++;
            end
            else
            begin
                head_byte = expected_bytes.pop_front();
                if (m_tdata[7:0] !== head_byte.value)
                begin
                    $error("out_byte: expected %0h, actual %0h", head_byte.value, m_tdata[7:0]);
                    errors++;
                end
                if (m_tdata[23:8] !== head_byte.index)
                begin
                    $error("byte_index: expected %0d, actual %0d",
                           head_byte.index, m_tdata[23:8]);
                    errors++;
                end
                if (m_tlast !== head_byte.last)
                begin
                    $error("last: expected %0b, actual %0b", head_byte.last, m_tlast);
                    errors++;
                end
                if (m_tuser[0] !== head_byte.failed)
                begin
                    $error("failed: expected %0b, actual %0b", head_byte.failed, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    always @(negedge clk)
    begin
        sink_tick <= sink_tick + 1;
        if (sink_tick % 97 == 0)
            sink_mode <= $urandom_range(0, 3);
        case (sink_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            2:       m_tready <= (sink_tick % 5 < 2);
            default: m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [63:0] value,
                             input logic [5:0] nbits, input logic scaled, input logic bad_id);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, nbits, value};
        s_tuser  <= {bad_id, scaled, op};
        do
            @(posedge clk);
        while (!s_tready);
        predict_packed_bytes(op, value, nbits, scaled, bad_id);
        @(negedge clk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [15:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        apply_reg(idx, value);
        @(negedge clk);
    endtask

    task automatic test_header_and_raw();
        send_item(OP_START, 64'hFFFF_FFFF_FFFF_FF5A, 6'h3F, 1'b1, 1'b1);
        send_item(OP_RAW, 64'h1, 6'd1, 1'b0, 1'b0);
        send_item(OP_RAW, '1, 6'd32, 1'b0, 1'b0);
        send_item(OP_RAW, '1, 6'd0, 1'b1, 1'b1);
        send_item(OP_RAW, 64'h8000_0000_1234_5678, 6'd63, 1'b0, 1'b0);
        send_item(OP_FLUSH, '0, 6'd0, 1'b0, 1'b0);
    endtask

    task automatic test_time_classes();
        send_item(OP_TIME, 64'd16382, 6'd0, 1'b0, 1'b0);
        send_item(OP_TIME, 64'd16383, 6'd0, 1'b0, 1'b0);
        send_item(OP_TIME, 64'd262143, 6'd0, 1'b0, 1'b0);
        send_item(OP_TIME, 64'd67108863, 6'd0, 1'b0, 1'b0);
        send_item(OP_TIME, '1, 6'd0, 1'b1, 1'b0);
        send_item(OP_TIME, (64'd16382 << TIME_SCALE_SHIFT) | 64'h1F, 6'd0, 1'b1, 1'b0);
        send_item(OP_TIME, 64'd0, 6'd0, 1'b1, 1'b0);
    endtask

    task automatic test_net_ids();
        send_item(OP_NET_ID, 64'hABCD_0000_0000_FFFF, 6'd0, 1'b0, 1'b1);
        settle();
        write_reg(REG_MULTIPLAYER, 16'd1);
        write_reg(REG_LOW_ID_COUNT, 16'd100);
        write_reg(REG_LOW_ID_BITS, 16'd7);
        write_reg(REG_MEDIUM_ID_BITS, 16'd20);
        write_reg(REG_HIGH_ID_START, 16'd1000);
        write_reg(REG_HIGH_ID_BITS, 16'd0);
        write_reg(REG_INVALID_ID_CODE, 16'd300);
        send_item(OP_NET_ID, 64'd5, 6'd0, 1'b0, 1'b0);
        send_item(OP_NET_ID, 64'd100, 6'd0, 1'b0, 1'b0);
        send_item(OP_NET_ID, 64'hFFFF, 6'd0, 1'b0, 1'b0);
        send_item(OP_NET_ID, 64'd1000, 6'd0, 1'b0, 1'b0);
        send_item(OP_NET_ID, 64'd5, 6'd0, 1'b0, 1'b1);
    endtask

    task automatic test_flush_and_unused();
        send_item(OP_FLUSH, '0, 6'd0, 1'b0, 1'b0);
        send_item(OP_FLUSH, '1, 6'h3F, 1'b1, 1'b1);
        for (int k = int'(OP_FLUSH) + 1; k <= OPCODE_TOP; k++)
            send_item(OPCODE_W'(k), '1, 6'h3F, 1'b1, 1'b1);
    endtask

    task automatic test_capacity();
        settle();
        write_reg(REG_BUFFER_BYTES, 16'd2);
        send_item(OP_START, 64'h3C, 6'd0, 1'b0, 1'b0);
        send_item(OP_TIME, '1, 6'd0, 1'b0, 1'b0);
        send_item(OP_START, 64'hC3, 6'd0, 1'b0, 1'b0);
        settle();
        write_reg(REG_BUFFER_BYTES, 16'd0);
        send_item(OP_START, 64'h81, 6'd0, 1'b0, 1'b0);
        settle();
        write_reg(REG_BUFFER_BYTES, 16'd1024);
        send_item(OP_RAW, 64'h96, 6'd8, 1'b0, 1'b0);
    endtask

    task automatic configure_phase(input int unsigned phase);
        logic        mp;
        logic [15:0] lo_cnt;
        logic [15:0] hi_start;
        logic [15:0] bad_code;
        logic [15:0] cap;
        logic [4:0]  lo_w;
        logic [4:0]  mid_w;
        logic [4:0]  hi_w;
        mp       = 1'($urandom_range(0, 1));
        lo_cnt   = 16'($urandom);
        hi_start = 16'($urandom);
        bad_code = 16'($urandom);
        lo_w     = 5'($urandom);
        mid_w    = 5'($urandom);
        hi_w     = 5'($urandom);
        cap      = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 8))
                                               : 16'($urandom_range(9, 65535));
        if (phase == 0)
        begin
            mp = 1'b1; lo_cnt = '1; hi_start = '1; bad_code = '1;
            lo_w = '1; mid_w = '1; hi_w = '1; cap = '1;
        end
        else if (phase == 1)
        begin
            mp = 1'b1; lo_cnt = '0; hi_start = '0; bad_code = '0;
            lo_w = '0; mid_w = '0; hi_w = '0; cap = 16'd1;
        end
        else if (phase == 2)
            mp = 1'b0;
        write_reg(REG_MULTIPLAYER, {15'($urandom), mp});
        write_reg(REG_LOW_ID_COUNT, lo_cnt);
        write_reg(REG_LOW_ID_BITS, {11'($urandom), lo_w});
        write_reg(REG_MEDIUM_ID_BITS, {11'($urandom), mid_w});
        write_reg(REG_HIGH_ID_START, hi_start);
        write_reg(REG_HIGH_ID_BITS, {11'($urandom), hi_w});
        write_reg(REG_INVALID_ID_CODE, bad_code);
        write_reg(REG_BUFFER_BYTES, cap);
    endtask

    task automatic random_field();
        logic [63:0] value;
        logic [5:0]  nbits;
        logic [15:0] id;
        logic        scaled;
        int unsigned pick;
        value  = {$urandom, $urandom};
        nbits  = 6'($urandom);
        scaled = 1'($urandom_range(0, 1));
        pick   = $urandom_range(0, 9);
        if (pick < 4)
        begin
            if ($urandom_range(0, 7) != 0)
                nbits = 6'($urandom_range(1, RAW_BITS_MAX));
            send_item(OP_RAW, value, nbits, scaled, 1'($urandom_range(0, 1)));
        end
        else if (pick < 7)
        begin
            case ($urandom_range(0, 4))
                0:       value = value & 64'h3FFF;
                1:       value = value & 64'h3_FFFF;
                2:       value = value & 64'h3FF_FFFF;
                3:       value = value & 64'h3F_FFFF_FFFF;
                default: value = value;
            endcase
            if (scaled && value < 64'h40_0000_0000)
                value = {value[58:0], 5'($urandom)};
            send_item(OP_TIME, value, nbits, scaled, 1'($urandom_range(0, 1)));
        end
        else if (pick < 9)
        begin
            id = value[15:0];
            case ($urandom_range(0, 2))
                0:       id = cur_low_id_count + 16'($urandom_range(0, 7)) - 16'd4;
                1:       id = cur_high_id_start + 16'($urandom_range(0, 7)) - 16'd4;
                default: id = id;
            endcase
            value[15:0] = id;
            send_item(OP_NET_ID, value, nbits, scaled, ($urandom_range(0, 5) == 0));
        end
        else
            send_item(OP_FLUSH, value, nbits, scaled, 1'($urandom_range(0, 1)));
    endtask

    task automatic random_packet();
        int unsigned fields;
        if ($urandom_range(0, 7) != 0)
            send_item(OP_START, {$urandom, $urandom}, 6'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        fields = $urandom_range(1, 10);
        repeat (fields) random_field();
        if ($urandom_range(0, 4) != 0)
            send_item(OP_FLUSH, {$urandom, $urandom}, 6'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0)
            send_item(OPCODE_W'($urandom_range(int'(OP_FLUSH) + 1, OPCODE_TOP)),
                      {$urandom, $urandom}, 6'($urandom),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_random_traffic();
        int unsigned first;
        int unsigned phase_first;
        int unsigned phase;
        first = accepted_ops;
        phase = 0;
        while (accepted_ops - first < RANDOM_ITEMS)
        begin
            settle();
            configure_phase(phase);
            phase_first = accepted_ops;
            while (accepted_ops - phase_first < PHASE_ITEMS)
                random_packet();
            phase++;
        end
    endtask

    initial
    begin
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_header_and_raw();
        test_time_classes();
        test_net_ids();
        test_flush_and_unused();
        test_capacity();
        test_random_traffic();
        settle();
        if (errors == 0 && expected_bytes.size() == 0)
            $display("prefix_coded_bit_packer_top verification clean");
        else
            $display("prefix_coded_bit_packer_top verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/pcbp_pkg.sv
sv/pcbp_front.sv
sv/pcbp_queue.sv
sv/pcbp_back.sv
sv/prefix_coded_bit_packer_top.sv
dv/prefix_coded_bit_packer_top_tb.sv
